### sv/eswseq_pkg.sv
package eswseq_pkg;

    localparam int DEFAULT_WORDS = 2048;
    localparam int CFG_INDEX_W   = 2;

    localparam logic [1:0] FUNC_BYTE       = 2'd0;
    localparam logic [1:0] FUNC_HALF       = 2'd1;
    localparam logic [1:0] FUNC_WORD       = 2'd2;
    localparam logic [1:0] FUNC_MASS_ERASE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_DIVIDER_LOADED = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_BEGIN   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END     = 2'd2;

    localparam logic [7:0] CMD_PROGRAM      = 8'h20;
    localparam logic [7:0] CMD_SECTOR_ERASE = 8'h40;
    localparam logic [7:0] CMD_MASS_ERASE   = 8'h41;

    localparam logic [15:0] ERASED_WORD       = 16'hFFFF;
    localparam logic [15:0] MASS_ADDR         = 16'h0400;
    localparam logic [15:0] WINDOW_BEGIN_INIT = 16'd1024;
    localparam logic [15:0] WINDOW_END_INIT   = 16'd4095;

    function automatic logic cmd_allowed(
        input logic        divider,
        input logic [15:0] addr,
        input logic [15:0] win_begin,
        input logic [15:0] win_end
    );
        return divider && (addr >= win_begin) && (addr <= win_end);
    endfunction

endpackage

### sv/eeprom_sector_write_sequencer_core.sv
// full write request: first result after the index, read and merge steps (the index step
// has more registers when WORDS is not a power of two), then one per cycle
// write refused at its sector erase: one result
// misaligned request or refused mass erase: one result the next cycle
// mass erase: one mirror word written per cycle; after reset busy stays
// high while the mirror is swept to all ones; the receiver cannot stall
module eeprom_sector_write_sequencer_core #(
    parameter int WORDS = eswseq_pkg::DEFAULT_WORDS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write_en,
    input  logic [eswseq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]                        cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         func,
    input  logic [15:0]                        bus_address,
    input  logic [31:0]                        write_value,
    output logic                               result_strobe,
    output logic                               issued,
    output logic [7:0]                         command_code,
    output logic [15:0]                        word_address,
    output logic [15:0]                        word_data,
    output logic                               last,
    output logic                               success
);
    import eswseq_pkg::*;

    localparam int IW = (WORDS > 1) ? $clog2(WORDS) : 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLEAR   = 4'd1;
    localparam logic [3:0] S_INDEX   = 4'd2;
    localparam logic [3:0] S_READ    = 4'd3;
    localparam logic [3:0] S_MERGE   = 4'd4;
    localparam logic [3:0] S_ERASE   = 4'd5;
    localparam logic [3:0] S_PROG_HI = 4'd6;
    localparam logic [3:0] S_PROG_LO = 4'd7;
    localparam logic [3:0] S_MASS    = 4'd8;

    logic [3:0]    state_reg, state_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic [1:0]    func_reg, func_next;
    logic [15:0]   addr_reg, addr_next;
    logic [31:0]   value_reg, value_next;
    logic [15:0]   hi_reg, hi_next;
    logic [15:0]   lo_reg, lo_next;

    logic          divider_reg;
    logic [15:0]   wbegin_reg;
    logic [15:0]   wend_reg;

    logic          strobe_reg, strobe_next;
    logic          issued_reg, issued_next;
    logic [7:0]    code_reg, code_next;
    logic [15:0]   waddr_reg, waddr_next;
    logic [15:0]   wdata_reg, wdata_next;
    logic          last_reg, last_next;
    logic          success_reg, success_next;

    logic          accept;
    logic          idx_start;
    logic          idx_done;
    logic [IW-1:0] idx0, idx1;
    logic          rd_en;
    logic [15:0]   rd_a, rd_b;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    logic [15:0]   wr_data;

    logic [15:0]   base;
    logic [15:0]   base_plus2;
    logic [15:0]   hw_word;
    logic [15:0]   byte_word;
    logic [15:0]   half;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign base       = {addr_reg[15:2], 2'b00};
    assign base_plus2 = base + 16'd2;

    // byte and halfword merge into the sector read back from the mirror
    assign hw_word   = addr_reg[1] ? rd_b : rd_a;
    assign byte_word = addr_reg[0] ? {hw_word[15:8], value_reg[7:0]}
                                   : {value_reg[7:0], hw_word[7:0]};
    assign half      = (func_reg == FUNC_BYTE) ? byte_word : value_reg[15:0];

    eswseq_index #(
        .WORDS (WORDS),
        .IW    (IW)
    ) u_index (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (idx_start),
        .word_addr ({bus_address[15:2], 1'b0}),
        .done      (idx_done),
        .idx0      (idx0),
        .idx1      (idx1)
    );

    eswseq_mem #(
        .WORDS (WORDS),
        .IW    (IW)
    ) u_mem (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr_a (idx0),
        .rd_addr_b (idx1),
        .rd_data_a (rd_a),
        .rd_data_b (rd_b),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data)
    );

    always_comb
    begin
        state_next   = state_reg;
        sweep_next   = sweep_reg;
        func_next    = func_reg;
        addr_next    = addr_reg;
        value_next   = value_reg;
        hi_next      = hi_reg;
        lo_next      = lo_reg;
        strobe_next  = 1'b0;
        issued_next  = 1'b0;
        code_next    = '0;
        waddr_next   = '0;
        wdata_next   = '0;
        last_next    = 1'b1;
        success_next = 1'b0;
        idx_start    = 1'b0;
        rd_en        = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = idx1;
        wr_data      = ERASED_WORD;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    func_next  = func;
                    addr_next  = bus_address;
                    value_next = write_value;
                    sweep_next = '0;
                    if ((func == FUNC_HALF && bus_address[0])
                        || (func == FUNC_WORD && bus_address[1:0] != 2'b00))
                    begin
                        strobe_next = 1'b1;
                    end
                    else if (func == FUNC_MASS_ERASE)
                    begin
                        if (cmd_allowed(divider_reg, MASS_ADDR, wbegin_reg, wend_reg))
                        begin
                            state_next = S_MASS;
                        end
                        else
                        begin
                            strobe_next = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_start  = 1'b1;
                        state_next = S_INDEX;
                    end
                end
            end
            S_CLEAR, S_MASS:
            begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + IW'(1);
                if (sweep_reg == IW'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                    if (state_reg == S_MASS)
                    begin
                        strobe_next  = 1'b1;
                        issued_next  = 1'b1;
                        code_next    = CMD_MASS_ERASE;
                        waddr_next   = MASS_ADDR;
                        wdata_next   = ERASED_WORD;
                        success_next = 1'b1;
                    end
                end
            end
            S_INDEX:
            begin
                if (idx_done)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                state_next = S_MERGE;
            end
            S_MERGE:
            begin
                if (func_reg == FUNC_WORD)
                begin
                    hi_next = value_reg[31:16];
                    lo_next = value_reg[15:0];
                end
                else
                begin
                    hi_next = addr_reg[1] ? rd_a : half;
                    lo_next = addr_reg[1] ? half : rd_b;
                end
                state_next = S_ERASE;
            end
            S_ERASE:
            begin
                strobe_next = 1'b1;
                if (cmd_allowed(divider_reg, base, wbegin_reg, wend_reg))
                begin
                    // low word erased here, high word is overwritten by its program next
                    wr_en       = 1'b1;
                    issued_next = 1'b1;
                    code_next   = CMD_SECTOR_ERASE;
                    waddr_next  = base;
                    wdata_next  = ERASED_WORD;
                    last_next   = 1'b0;
                    state_next  = S_PROG_HI;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PROG_HI:
            begin
                // same address as the erase, so it cannot be refused
                wr_en       = 1'b1;
                wr_addr     = idx0;
                wr_data     = hi_reg;
                strobe_next = 1'b1;
                issued_next = 1'b1;
                code_next   = CMD_PROGRAM;
                waddr_next  = base;
                wdata_next  = hi_reg;
                last_next   = 1'b0;
                state_next  = S_PROG_LO;
            end
            S_PROG_LO:
            begin
                strobe_next = 1'b1;
                state_next  = S_IDLE;
                if (cmd_allowed(divider_reg, base_plus2, wbegin_reg, wend_reg))
                begin
                    wr_en        = 1'b1;
                    wr_data      = lo_reg;
                    issued_next  = 1'b1;
                    code_next    = CMD_PROGRAM;
                    waddr_next   = base_plus2;
                    wdata_next   = lo_reg;
                    success_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            sweep_reg   <= '0;
            strobe_reg  <= 1'b0;
            divider_reg <= 1'b0;
            wbegin_reg  <= WINDOW_BEGIN_INIT;
            wend_reg    <= WINDOW_END_INIT;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            strobe_reg <= strobe_next;
            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    REG_DIVIDER_LOADED: divider_reg <= cfg_data[0];
                    REG_WINDOW_BEGIN:   wbegin_reg  <= cfg_data;
                    REG_WINDOW_END:     wend_reg    <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg    <= func_next;
        addr_reg    <= addr_next;
        value_reg   <= value_next;
        hi_reg      <= hi_next;
        lo_reg      <= lo_next;
        issued_reg  <= issued_next;
        code_reg    <= code_next;
        waddr_reg   <= waddr_next;
        wdata_reg   <= wdata_next;
        last_reg    <= last_next;
        success_reg <= success_next;
    end

    assign result_strobe = strobe_reg;
    assign issued        = issued_reg;
    assign command_code  = code_reg;
    assign word_address  = waddr_reg;
    assign word_data     = wdata_reg;
    assign last          = last_reg;
    assign success       = success_reg;

    // a refused command ends the request with a failure beat
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !issued) |-> (last && !success))
        else $error("failure beat not marked last without success");

    // a sector erase beat is always followed by the high word program
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && command_code == CMD_SECTOR_ERASE)
        |=> (result_strobe && issued && command_code == CMD_PROGRAM && !last))
        else $error("sector erase not followed by high word program");

    // an intermediate result only comes while a request is still in flight
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !last) |-> busy)
        else $error("intermediate beat while sequencer idle");

endmodule

### sv/eswseq_index.sv
module eswseq_index #(
    parameter int WORDS = eswseq_pkg::DEFAULT_WORDS,
    parameter int IW    = 11
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [14:0]   word_addr,
    output logic          done,
    output logic [IW-1:0] idx0,
    output logic [IW-1:0] idx1
);
    import eswseq_pkg::*;

    localparam bit POW2 = ((WORDS & (WORDS - 1)) == 0);

    logic          done_reg;
    logic [IW-1:0] idx_reg;

    generate
        if (POW2) begin : g_mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    idx_reg <= word_addr[IW-1:0];
                end
            end
        end
        else begin : g_recip
            // remainder by reciprocal multiply: the quotient estimate is low by at most one,
            // so a single compare and subtract finishes it
            localparam logic [14:0] RECIP = 15'(32768 / WORDS);

            logic          v1_reg;
            logic          v2_reg;
            logic [14:0]   x_reg;
            logic [29:0]   prod_reg;
            logic [15:0]   rem_reg;
            logic [29:0]   qw;

            assign qw = 30'(prod_reg[29:15]) * 30'(WORDS);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    v1_reg   <= 1'b0;
                    v2_reg   <= 1'b0;
                    done_reg <= 1'b0;
                end
                else
                begin
                    v1_reg   <= start;
                    v2_reg   <= v1_reg;
                    done_reg <= v2_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    x_reg    <= word_addr;
                    prod_reg <= 30'(word_addr) * 30'(RECIP);
                end
                if (v1_reg)
                begin
                    rem_reg <= {1'b0, x_reg} - qw[15:0];
                end
                if (v2_reg)
                begin
                    idx_reg <= (rem_reg >= 16'(WORDS)) ? IW'(rem_reg - 16'(WORDS))
                                                       : IW'(rem_reg);
                end
            end
        end
    endgenerate

    assign done = done_reg;
    assign idx0 = idx_reg;
    assign idx1 = (idx_reg == IW'(WORDS - 1)) ? '0 : idx_reg + IW'(1);

endmodule

### sv/eswseq_mem.sv
module eswseq_mem #(
    parameter int WORDS = eswseq_pkg::DEFAULT_WORDS,
    parameter int IW    = 11
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [IW-1:0] rd_addr_a,
    input  logic [IW-1:0] rd_addr_b,
    output logic [15:0]   rd_data_a,
    output logic [15:0]   rd_data_b,
    input  logic          wr_en,
    input  logic [IW-1:0] wr_addr,
    input  logic [15:0]   wr_data
);
    import eswseq_pkg::*;

    logic [15:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_a <= mem[rd_addr_a];
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
